[hdl/assert_macros.svh]
// Assertion macros used by the checker file uvs_checker.sv.
// Each macro expects signals clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hdl/uvs_pkg.sv]
// Shared types, constants and helper functions of the UV sphere tessellator.
// No dependencies.
package uvs_pkg;

	localparam int MAX_GRID         = 256;
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_RADIUS = 2'd0,
		REG_RINGS  = 2'd1,
		REG_SLICES = 2'd2,
		REG_COLOR  = 2'd3
	} cfg_reg_t;

	// control side band that rides along the pipeline
	typedef struct packed {
		logic valid;
		logic up;
		logic lo;
	} ctrl_t;

	// one restoring division step: returns {quotient bit, new remainder}
	function automatic logic [8:0] div_step(input logic [7:0] rem, input logic b,
			input logic [8:0] d);
		logic [8:0] r;
		logic [8:0] diff;
		r    = {rem, b};
		diff = r - d;
		if (r >= d) begin
			return {1'b1, diff[7:0]};
		end else begin
			return {1'b0, r[7:0]};
		end
	endfunction

	// Q30 Taylor series of sin(x), rounded to Q1.14 and clamped
	function automatic logic [14:0] sine_q14(input logic [63:0] x);
		logic [63:0] t;
		logic signed [63:0] s;
		logic signed [63:0] v;
		t = x;
		s = $signed(x);
		t = ((((t * x) >> 30) * x) >> 30) / 64'd6;   s = s - $signed(t);
		t = ((((t * x) >> 30) * x) >> 30) / 64'd20;  s = s + $signed(t);
		t = ((((t * x) >> 30) * x) >> 30) / 64'd42;  s = s - $signed(t);
		t = ((((t * x) >> 30) * x) >> 30) / 64'd72;  s = s + $signed(t);
		t = ((((t * x) >> 30) * x) >> 30) / 64'd110; s = s - $signed(t);
		t = ((((t * x) >> 30) * x) >> 30) / 64'd156; s = s + $signed(t);
		t = ((((t * x) >> 30) * x) >> 30) / 64'd210; s = s - $signed(t);
		t = ((((t * x) >> 30) * x) >> 30) / 64'd272; s = s + $signed(t);
		if (s < 0) begin
			s = 0;
		end
		v = (s + 64'sd32768) >>> 16;
		if (v > 64'sd16384) begin
			v = 64'sd16384;
		end
		return v[14:0];
	endfunction

	// round prod >> sh half away from zero, saturate to a signed field of width bits
	function automatic logic [63:0] round_sat(input logic signed [63:0] prod, input int sh,
			input int width);
		logic neg;
		logic [63:0] mag;
		logic [63:0] lim;
		neg = prod < 0;
		mag = neg ? (64'd0 - 64'(prod)) : 64'(prod);
		lim = neg ? (64'd1 << (width - 1)) : ((64'd1 << (width - 1)) - 64'd1);
		mag = (mag + (64'd1 << (sh - 1))) >> sh;
		if (mag > lim) begin
			mag = lim;
		end
		return (neg ? (64'd0 - mag) : mag) & ((64'd1 << width) - 64'd1);
	endfunction

endpackage

[hdl/uvs_div.sv]
// Three-stage restoring divider for grid angles: 25-bit dividend, 9-bit divisor,
// 17-bit quotient. Uses uvs_pkg.
module uvs_div (
	input  logic        clk,
	input  logic        en,
	input  logic [24:0] dividend,
	input  logic [8:0]  divisor,
	output logic [16:0] quot
);
	import uvs_pkg::*;

	logic [7:0]  rem_s2, rem_s3;
	logic [5:0]  q_s2;
	logic [11:0] q_s3;
	logic [10:0] low_s2;
	logic [4:0]  low_s3;
	logic [16:0] q_s4;
	logic [7:0]  rem_a, rem_b, rem_c;
	logic [5:0]  qa, qb;
	logic [4:0]  qc;
	logic [8:0]  st_a, st_b, st_c;

	// first six quotient bits; top dividend bits are known to stay below the divisor
	always_comb begin
		rem_a = dividend[24:17];
		qa    = '0;
		st_a  = '0;
		for (int i = 0; i < 6; i++) begin
			st_a      = div_step(rem_a, dividend[16 - i], divisor);
			qa[5 - i] = st_a[8];
			rem_a     = st_a[7:0];
		end
	end

	// next six bits
	always_comb begin
		rem_b = rem_s2;
		qb    = '0;
		st_b  = '0;
		for (int i = 0; i < 6; i++) begin
			st_b      = div_step(rem_b, low_s2[10 - i], divisor);
			qb[5 - i] = st_b[8];
			rem_b     = st_b[7:0];
		end
	end

	// last five bits
	always_comb begin
		rem_c = rem_s3;
		qc    = '0;
		st_c  = '0;
		for (int i = 0; i < 5; i++) begin
			st_c      = div_step(rem_c, low_s3[4 - i], divisor);
			qc[4 - i] = st_c[8];
			rem_c     = st_c[7:0];
		end
	end

	// advance the stages together
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s2 <= rem_a;
			q_s2   <= qa;
			low_s2 <= dividend[10:0];
			rem_s3 <= rem_b;
			q_s3   <= {q_s2, qb};
			low_s3 <= low_s2[4:0];
			q_s4   <= {q_s3, qc};
		end
	end

	assign quot = q_s4;

endmodule

[hdl/uvs_trig.sv]
// Two-stage sine and cosine of a 16-bit turn angle through a quarter-wave table.
// Uses uvs_pkg for the table generator.
module uvs_trig #(
	parameter int SineTableDepth = uvs_pkg::SINE_TABLE_DEPTH
) (
	input  logic               clk,
	input  logic               en,
	input  logic [15:0]        angle,
	output logic signed [15:0] sin_val,
	output logic signed [15:0] cos_val
);
	import uvs_pkg::*;

	localparam int IdxW = $clog2(SineTableDepth + 1);

	logic [14:0]     sine_tab [SineTableDepth + 1];
	logic [IdxW-1:0] sin_idx, cos_idx;
	logic            sin_neg, cos_neg;
	logic [IdxW-1:0] sin_idx_s5, cos_idx_s5;
	logic            sin_neg_s5, cos_neg_s5;
	logic signed [15:0] sin_s6, cos_s6;
	logic [15:0]     cos_angle;

	// constant quarter-wave table, one entry per step of a quarter turn
	for (genvar k = 0; k <= SineTableDepth; k++) begin : g_tab
		localparam logic [63:0] X = (64'(k) * HALF_PI_Q30) / SineTableDepth;
		assign sine_tab[k] = sine_q14(X);
	end

	function automatic logic [IdxW:0] prep(input logic [15:0] a);
		logic [31:0] full;
		logic [IdxW-1:0] idx;
		full = (32'(a[13:0]) * 32'(SineTableDepth) + 32'd8192) >> 14;
		if (full > 32'(SineTableDepth)) begin
			idx = IdxW'(SineTableDepth);
		end else begin
			idx = full[IdxW-1:0];
		end
		if (a[14]) begin
			idx = IdxW'(SineTableDepth) - idx;
		end
		return {a[15], idx};
	endfunction

	assign cos_angle = angle + 16'd16384;

	// quadrant fold into table index and sign
	always_ff @(posedge clk) begin
		if (en) begin
			{sin_neg_s5, sin_idx_s5} <= prep(angle);
			{cos_neg_s5, cos_idx_s5} <= prep(cos_angle);
		end
	end

	assign sin_idx = sin_idx_s5;
	assign cos_idx = cos_idx_s5;
	assign sin_neg = sin_neg_s5;
	assign cos_neg = cos_neg_s5;

	// table read and sign
	always_ff @(posedge clk) begin
		if (en) begin
			sin_s6 <= sin_neg ? -$signed({1'b0, sine_tab[sin_idx]})
			                  : $signed({1'b0, sine_tab[sin_idx]});
			cos_s6 <= cos_neg ? -$signed({1'b0, sine_tab[cos_idx]})
			                  : $signed({1'b0, sine_tab[cos_idx]});
		end
	end

	assign sin_val = sin_s6;
	assign cos_val = cos_s6;

endmodule

[hdl/uvs_corner.sv]
// Two-stage corner arithmetic: position radius*sin*cos and unit normal, rounded
// and saturated. Uses uvs_pkg.
module uvs_corner (
	input  logic               clk,
	input  logic               en,
	input  logic [15:0]        radius,
	input  logic signed [15:0] st,
	input  logic signed [15:0] ct,
	input  logic signed [15:0] sp,
	input  logic signed [15:0] cp,
	output logic [53:0]        pos,
	output logic [47:0]        nrm
);
	import uvs_pkg::*;

	logic signed [31:0] a_s7, b_s7;
	logic signed [32:0] ry_s7;
	logic signed [15:0] ct_s7;
	logic signed [48:0] px_s8, pz_s8;
	logic [17:0]        py_s8;
	logic [15:0]        nx_s8, ny_s8, nz_s8;
	logic [63:0]        px_r, pz_r, py_r, nx_r, nz_r;
	logic signed [16:0] r_sg;

	assign r_sg = $signed({1'b0, radius});

	// trig products
	always_ff @(posedge clk) begin
		if (en) begin
			a_s7  <= st * cp;
			b_s7  <= st * sp;
			ry_s7 <= r_sg * ct;
			ct_s7 <= ct;
		end
	end

	assign py_r = round_sat(64'(ry_s7), 14, 18);
	assign nx_r = round_sat(64'(a_s7), 14, 16);
	assign nz_r = round_sat(64'(b_s7), 14, 16);

	// radius scaling, normals finished
	always_ff @(posedge clk) begin
		if (en) begin
			px_s8 <= r_sg * a_s7;
			pz_s8 <= r_sg * b_s7;
			py_s8 <= py_r[17:0];
			nx_s8 <= nx_r[15:0];
			nz_s8 <= nz_r[15:0];
			ny_s8 <= ct_s7;
		end
	end

	assign px_r = round_sat(64'(px_s8), 28, 18);
	assign pz_r = round_sat(64'(pz_s8), 28, 18);

	assign pos = {pz_r[17:0], py_s8, px_r[17:0]};
	assign nrm = {nz_s8, ny_s8, nx_s8};

endmodule

[hdl/uv_sphere_tessellator.sv]
// Takes one (ring, slice) cell of a UV sphere per word and returns zero, one or two
// triangles with positions, normals and color. A cell enters every cycle unless held.
// The single result register hands out one triangle per cycle while out_ready is high,
// so a two-triangle cell occupies it for both triangles and holds the pipeline during
// the upper one; one-triangle and empty cells flow at one per cycle under the same
// condition. Angle division runs in a three-stage divider, trig in two, corner math in two.
// Configuration is taken every cycle and must only change while the block is idle.
module uv_sphere_tessellator #(
	parameter int SineTableDepth = uvs_pkg::SINE_TABLE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ring_index,
	input  logic [7:0]  slice_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [53:0] vertex_a,
	output logic [53:0] vertex_b,
	output logic [53:0] vertex_c,
	output logic [47:0] normal_a,
	output logic [47:0] normal_b,
	output logic [47:0] normal_c,
	output logic [31:0] tri_color,
	output logic        lower_half,
	output logic        last_of_cell
);
	import uvs_pkg::*;

	logic [15:0] sphere_radius_q;
	logic [8:0]  ring_count_q, slice_count_q;
	logic [31:0] triangle_color_q;
	logic [8:0]  n_eff, m_eff;
	logic        en;
	ctrl_t       ctrl_in;
	ctrl_t       ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5, ctrl_s6, ctrl_s7, ctrl_s8;
	logic [24:0] dt1_s1, dt2_s1, dp1_s1, dp2_s1;
	logic [16:0] qt1, qt2, qp1, qp2;
	logic signed [15:0] st1, ct1, st2, ct2, sp1, cp1, sp2, cp2;
	logic [53:0] pos1, pos2, pos3, pos4;
	logic [47:0] nrm1, nrm2, nrm3, nrm4;
	logic        cell_valid_q, phase_q, lo_q;
	logic [53:0] v1_q, v2_q, v3_q, v4_q;
	logic [47:0] n1_q, n2_q, n3_q, n4_q;
	logic        out_fire, cell_done;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sphere_radius_q  <= 16'd256;
			ring_count_q     <= 9'd16;
			slice_count_q    <= 9'd16;
			triangle_color_q <= 32'hFFFF_FFFF;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_RADIUS: sphere_radius_q  <= cfg_data[15:0];
				REG_RINGS:  ring_count_q     <= cfg_data[8:0];
				REG_SLICES: slice_count_q    <= cfg_data[8:0];
				REG_COLOR:  triangle_color_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// clamp counts to the grid limit
	assign n_eff = (ring_count_q > 9'(MAX_GRID)) ? 9'(MAX_GRID) : ring_count_q;
	assign m_eff = (slice_count_q > 9'(MAX_GRID)) ? 9'(MAX_GRID) : slice_count_q;

	// pipeline moves whenever the result register is free or freeing
	assign out_fire  = out_valid && out_ready;
	assign cell_done = out_fire && last_of_cell;
	assign en        = !cell_valid_q || cell_done;
	assign in_ready  = en;

	// drop out-of-range cells at the door, flag which triangles exist
	always_comb begin
		ctrl_in.valid = in_valid && ({1'b0, ring_index} < n_eff)
		                && ({1'b0, slice_index} < m_eff);
		ctrl_in.up    = ring_index != 8'd0;
		ctrl_in.lo    = {1'b0, ring_index} != (n_eff - 9'd1);
	end

	// input stage: angle dividends with half-divisor rounding
	always_ff @(posedge clk) begin
		if (en) begin
			dt1_s1 <= (25'(ring_index) << 15) + 25'(n_eff >> 1);
			dt2_s1 <= ((25'(ring_index) + 25'd1) << 15) + 25'(n_eff >> 1);
			dp1_s1 <= (25'(slice_index) << 16) + 25'(m_eff >> 1);
			dp2_s1 <= ((25'(slice_index) + 25'd1) << 16) + 25'(m_eff >> 1);
		end
	end

	// control side band, valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
			ctrl_s5 <= '0;
			ctrl_s6 <= '0;
			ctrl_s7 <= '0;
			ctrl_s8 <= '0;
		end else if (en) begin
			ctrl_s1 <= ctrl_in;
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= ctrl_s3;
			ctrl_s5 <= ctrl_s4;
			ctrl_s6 <= ctrl_s5;
			ctrl_s7 <= ctrl_s6;
			ctrl_s8 <= ctrl_s7;
		end
	end

	// angle dividers
	uvs_div u_div_t1 (.clk(clk), .en(en), .dividend(dt1_s1), .divisor(n_eff), .quot(qt1));
	uvs_div u_div_t2 (.clk(clk), .en(en), .dividend(dt2_s1), .divisor(n_eff), .quot(qt2));
	uvs_div u_div_p1 (.clk(clk), .en(en), .dividend(dp1_s1), .divisor(m_eff), .quot(qp1));
	uvs_div u_div_p2 (.clk(clk), .en(en), .dividend(dp2_s1), .divisor(m_eff), .quot(qp2));

	// trig of the four angles
	uvs_trig #(.SineTableDepth(SineTableDepth)) u_trig_t1 (
		.clk(clk), .en(en), .angle(qt1[15:0]), .sin_val(st1), .cos_val(ct1));
	uvs_trig #(.SineTableDepth(SineTableDepth)) u_trig_t2 (
		.clk(clk), .en(en), .angle(qt2[15:0]), .sin_val(st2), .cos_val(ct2));
	uvs_trig #(.SineTableDepth(SineTableDepth)) u_trig_p1 (
		.clk(clk), .en(en), .angle(qp1[15:0]), .sin_val(sp1), .cos_val(cp1));
	uvs_trig #(.SineTableDepth(SineTableDepth)) u_trig_p2 (
		.clk(clk), .en(en), .angle(qp2[15:0]), .sin_val(sp2), .cos_val(cp2));

	// four corners: (t1,p1) (t1,p2) (t2,p2) (t2,p1)
	uvs_corner u_c1 (.clk(clk), .en(en), .radius(sphere_radius_q),
		.st(st1), .ct(ct1), .sp(sp1), .cp(cp1), .pos(pos1), .nrm(nrm1));
	uvs_corner u_c2 (.clk(clk), .en(en), .radius(sphere_radius_q),
		.st(st1), .ct(ct1), .sp(sp2), .cp(cp2), .pos(pos2), .nrm(nrm2));
	uvs_corner u_c3 (.clk(clk), .en(en), .radius(sphere_radius_q),
		.st(st2), .ct(ct2), .sp(sp2), .cp(cp2), .pos(pos3), .nrm(nrm3));
	uvs_corner u_c4 (.clk(clk), .en(en), .radius(sphere_radius_q),
		.st(st2), .ct(ct2), .sp(sp1), .cp(cp1), .pos(pos4), .nrm(nrm4));

	// result register: load a cell with triangles, then step upper to lower
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_valid_q <= 1'b0;
			phase_q      <= 1'b0;
			lo_q         <= 1'b0;
		end else if (en) begin
			cell_valid_q <= ctrl_s8.valid && (ctrl_s8.up || ctrl_s8.lo);
			phase_q      <= !ctrl_s8.up;
			lo_q         <= ctrl_s8.lo;
		end else if (out_fire) begin
			phase_q <= 1'b1;
		end
	end

	// corner payload, no reset
	always_ff @(posedge clk) begin
		if (en) begin
			v1_q <= pos1;
			v2_q <= pos2;
			v3_q <= pos3;
			v4_q <= pos4;
			n1_q <= nrm1;
			n2_q <= nrm2;
			n3_q <= nrm3;
			n4_q <= nrm4;
		end
	end

	// present the current triangle
	assign out_valid    = cell_valid_q;
	assign lower_half   = phase_q;
	assign last_of_cell = phase_q || !lo_q;
	assign vertex_a     = v1_q;
	assign vertex_b     = phase_q ? v3_q : v2_q;
	assign vertex_c     = phase_q ? v4_q : v3_q;
	assign normal_a     = n1_q;
	assign normal_b     = phase_q ? n3_q : n2_q;
	assign normal_c     = phase_q ? n4_q : n3_q;
	assign tri_color    = triangle_color_q;

endmodule

[hdl/uvs_checker.sv]
// Port-level checks for the UV sphere tessellator, bound to the top level.
// Uses assert_macros.svh.
`include "assert_macros.svh"

module uvs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [53:0] vertex_a,
	input logic        lower_half,
	input logic        last_of_cell
);

	// a stalled word stays offered
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

	// a lower triangle always closes its cell
	`ASSERT_NOW(a_lower_last, out_valid && lower_half, last_of_cell)

	// an upper triangle that is not last is followed at once by its lower mate
	`ASSERT_NEXT(a_pair_next, out_valid && out_ready && !last_of_cell,
		out_valid && lower_half && $stable(vertex_a))

	// no new cell is taken while a cell is still being handed out
	`ASSERT_NOW(a_no_accept_mid, out_valid && !(out_ready && last_of_cell), !in_ready)

endmodule

bind uv_sphere_tessellator uvs_checker u_uvs_checker (.*);
